// ===== rtl/vpp_pkg.sv =====
`default_nettype none

package vpp_pkg;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int TEX_W     = 16;
  localparam int FRAC_BITS = 14;
  localparam int QUOT_W    = 20;   // perspective factor, Q6.14
  localparam int MUL_B_W   = 19;   // B operand of the shared multiplier
  localparam int K_W       = 36;   // scale * factor
  localparam int K_HALF    = 18;   // K goes through the multiplier in two halves

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COS_YAW         = 3'd0,
    REG_SIN_YAW         = 3'd1,
    REG_SCALE           = 3'd2,
    REG_CENTER_X        = 3'd3,
    REG_CENTER_Y        = 3'd4,
    REG_VERTICAL_OFFSET = 3'd5,
    REG_EYE_DISTANCE    = 3'd6
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_XC,
    ST_ZS,
    ST_XS,
    ST_ZC,
    ST_ZACC,
    ST_ZR,
    ST_DEN,
    ST_DSTART,
    ST_DWAIT,
    ST_KMUL,
    ST_KCAP,
    ST_XLO,
    ST_XHI,
    ST_YLO,
    ST_YHI,
    ST_YACC,
    ST_PY,
    ST_SY,
    ST_DONE
  } vpp_state_t;

  typedef enum logic [2:0] {
    A_X,
    A_Z,
    A_XR,
    A_YO,
    A_P
  } mul_a_sel_t;

  typedef enum logic [2:0] {
    B_COS,
    B_SIN,
    B_SCALE,
    B_K_LO,
    B_K_HI
  } mul_b_sel_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB,
    ACC_ADD_HI
  } acc_op_t;

  typedef struct packed {
    mul_a_sel_t a_sel;
    mul_b_sel_t b_sel;
    acc_op_t    acc_op;
    logic       in_ready;
    logic       cap_xr;
    logic       cap_zr;
    logic       cap_den;
    logic       div_start;
    logic       cap_k;
    logic       cap_px;
    logic       cap_sx;
    logic       cap_py;
    logic       cap_sy;
    logic       finish;
  } vpp_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/vpp_if.sv =====
`default_nettype none

interface vpp_in_if #(
  parameter int COORD_WIDTH = 16
) ();
  import vpp_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          first_vertex;
  logic signed [COORD_WIDTH-1:0] pos_x;
  logic signed [COORD_WIDTH-1:0] pos_y;
  logic signed [COORD_WIDTH-1:0] pos_z;
  logic        [TEX_W-1:0]       tex_u;
  logic        [TEX_W-1:0]       tex_v;

  modport source (
    output valid, first_vertex, pos_x, pos_y, pos_z, tex_u, tex_v,
    input  ready
  );

  modport sink (
    input  valid, first_vertex, pos_x, pos_y, pos_z, tex_u, tex_v,
    output ready
  );
endinterface

interface vpp_out_if #(
  parameter int COORD_WIDTH  = 16,
  parameter int SCREEN_WIDTH = 20
) ();
  import vpp_pkg::*;

  logic                           valid;
  logic                           ready;
  logic signed [SCREEN_WIDTH-1:0] screen_x;
  logic signed [SCREEN_WIDTH-1:0] screen_y;
  logic signed [COORD_WIDTH-1:0]  depth;
  logic        [TEX_W-1:0]        out_u;
  logic        [TEX_W-1:0]        out_v;
  logic signed [SCREEN_WIDTH-1:0] bound_min_x;
  logic signed [SCREEN_WIDTH-1:0] bound_min_y;
  logic signed [SCREEN_WIDTH-1:0] bound_max_x;
  logic signed [SCREEN_WIDTH-1:0] bound_max_y;

  modport source (
    output valid, screen_x, screen_y, depth, out_u, out_v,
           bound_min_x, bound_min_y, bound_max_x, bound_max_y,
    input  ready
  );

  modport sink (
    input  valid, screen_x, screen_y, depth, out_u, out_v,
           bound_min_x, bound_min_y, bound_max_x, bound_max_y,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/vertex_perspective_project_unit.sv =====
`default_nettype none

// Channel  Dir  Handshake         Payload
// in_if    in   valid / ready     first_vertex, pos_x/y/z, tex_u/v
// out_if   out  valid / ready     screen_x/y, depth, out_u/v, bound_min/max_x/y
// cfg_*    in   cfg_we            cfg_index, cfg_wdata (no read-back)
//
// One vertex at a time, in order: the idle state takes the request, then multiply/accumulate
// and setup states, the bit-serial divider for eye/(eye+rotated z), then the shared
// multiplier and the write-back. The result sits in an output register; the next vertex is
// taken meanwhile, and only the final write-back waits until the output register is free
// (empty or out_if.ready).
// Reset (rst_n low, synchronous) loads register defaults and empties the box.

module vertex_perspective_project_unit #(
  parameter int COORD_WIDTH  = 16,
  parameter int SCREEN_WIDTH = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [vpp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [vpp_pkg::CFG_W-1:0]        cfg_wdata,
  vpp_in_if.sink                           in_if,
  vpp_out_if.source                        out_if
);
  import vpp_pkg::*;

  localparam int CW  = COORD_WIDTH;
  localparam int SW  = SCREEN_WIDTH;
  localparam int VW  = (CW + 3 > CFG_W + 1) ? CW + 3 : CFG_W + 1;
  localparam int AW  = (VW > QUOT_W + 1) ? VW : QUOT_W + 1;
  localparam int PW  = AW + MUL_B_W;
  localparam int ACW = VW + CFG_W + QUOT_W + 1;
  localparam int PJW = ACW - 2 * FRAC_BITS;
  localparam int EW  = ((PJW > SW) ? PJW : SW) + 2;

  localparam logic signed [ACW-1:0] HALF_1X = ACW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [ACW-1:0] HALF_2X = ACW'(1) <<< (2 * FRAC_BITS - 1);
  localparam logic signed [EW-1:0]  SCR_MAX_E = {{(EW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [EW-1:0]  SCR_MIN_E = {{(EW-SW+1){1'b1}}, {(SW-1){1'b0}}};
  localparam logic signed [SW-1:0]  BOX_HI    = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0]  BOX_LO    = {1'b1, {(SW-1){1'b0}}};
  localparam logic signed [VW-1:0]  CRD_MAX_V = {{(VW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [VW-1:0]  CRD_MIN_V = {{(VW-CW+1){1'b1}}, {(CW-1){1'b0}}};

  localparam logic [CFG_W-1:0] COS_RST   = 16'd16384;
  localparam logic [CFG_W-1:0] SCALE_RST = 16'd4096;
  localparam logic [CFG_W-1:0] EYE_RST   = 16'd29491;

  vpp_ctrl_t ctrl;

  // configuration
  logic signed [CFG_W-1:0] cos_r, sin_r, voff_r;
  logic        [CFG_W-1:0] scale_r, cx_r, cy_r, eye_r;

  // item registers
  logic                  first_r;
  logic signed [CW-1:0]  x_r, z_r;
  logic signed [VW-1:0]  yo_r;
  logic [TEX_W-1:0]      u_r, v_r;
  logic signed [VW-1:0]  xr_r, zr_r;
  logic [VW-1:0]         den_r;
  logic [K_W-1:0]        k_r;
  logic signed [PJW-1:0] px_r, py_r;
  logic signed [SW-1:0]  sx_r, sy_r;
  logic signed [ACW-1:0] acc_r, acc_nxt;

  // box and output registers
  logic signed [SW-1:0]  box_min_x_r, box_min_y_r, box_max_x_r, box_max_y_r;
  logic signed [SW-1:0]  box_min_x_nxt, box_min_y_nxt, box_max_x_nxt, box_max_y_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [SW-1:0]  o_sx_r, o_sy_r;
  logic signed [CW-1:0]  o_depth_r;
  logic [TEX_W-1:0]      o_u_r, o_v_r;

  logic                     in_fire;
  logic                     out_free;
  logic signed [AW-1:0]     mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PW-1:0]     prod;
  acc_op_t                  prod_op;
  logic signed [ACW-1:0]    prod_ext, prod_hi;
  logic signed [ACW-1:0]    acc_rnd1, acc_rnd2;
  logic signed [VW:0]       den_sum;
  logic [VW-1:0]            den_nxt;
  logic                     div_busy;
  logic [QUOT_W-1:0]        persp;
  logic signed [EW-1:0]     sx_sum, sy_sum, sx_sat, sy_sat;
  logic signed [VW-1:0]     depth_sat;

  assign in_fire     = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;
  assign in_if.ready = ctrl.in_ready;

  vpp_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire_i  (in_fire),
    .div_busy_i (div_busy),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  always_comb begin
    case (ctrl.a_sel)
      A_X:     mul_a = AW'(x_r);
      A_Z:     mul_a = AW'(z_r);
      A_XR:    mul_a = AW'(xr_r);
      A_YO:    mul_a = AW'(yo_r);
      A_P:     mul_a = AW'(persp);
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    case (ctrl.b_sel)
      B_COS:   mul_b = MUL_B_W'(cos_r);
      B_SIN:   mul_b = MUL_B_W'(sin_r);
      B_SCALE: mul_b = MUL_B_W'(scale_r);
      B_K_LO:  mul_b = MUL_B_W'(k_r[K_HALF-1:0]);
      B_K_HI:  mul_b = MUL_B_W'(k_r[K_W-1:K_HALF]);
      default: mul_b = '0;
    endcase
  end

  vpp_mul #(
    .A_W (AW)
  ) u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .op_i   (ctrl.acc_op),
    .prod_o (prod),
    .op_o   (prod_op)
  );

  assign prod_ext = ACW'(prod);
  assign prod_hi  = prod_ext <<< K_HALF;

  always_comb begin
    case (prod_op)
      ACC_LOAD:   acc_nxt = prod_ext;
      ACC_ADD:    acc_nxt = acc_r + prod_ext;
      ACC_SUB:    acc_nxt = acc_r - prod_ext;
      ACC_ADD_HI: acc_nxt = acc_r + prod_hi;
      default:    acc_nxt = acc_r;
    endcase
  end

  // round half up, then drop the fraction bits
  assign acc_rnd1 = acc_r + HALF_1X;
  assign acc_rnd2 = acc_r + HALF_2X;

  // vertex at or behind the eye divides by one
  assign den_sum = (VW+1)'($signed({1'b0, eye_r})) + (VW+1)'(zr_r);
  assign den_nxt = (den_sum[VW] || den_sum == '0) ? VW'(1) : den_sum[VW-1:0];

  vpp_div #(
    .DEN_W (VW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (ctrl.div_start),
    .eye_i   (eye_r),
    .den_i   (den_r),
    .busy_o  (div_busy),
    .quot_o  (persp)
  );

  assign sx_sum = EW'($signed({1'b0, cx_r})) + EW'(px_r);
  assign sy_sum = EW'($signed({1'b0, cy_r})) - EW'(py_r);
  assign sx_sat = (sx_sum > SCR_MAX_E) ? SCR_MAX_E : ((sx_sum < SCR_MIN_E) ? SCR_MIN_E : sx_sum);
  assign sy_sat = (sy_sum > SCR_MAX_E) ? SCR_MAX_E : ((sy_sum < SCR_MIN_E) ? SCR_MIN_E : sy_sum);
  assign depth_sat = (zr_r > CRD_MAX_V) ? CRD_MAX_V : ((zr_r < CRD_MIN_V) ? CRD_MIN_V : zr_r);

  always_comb begin
    if (first_r) begin
      box_min_x_nxt = sx_r;
      box_max_x_nxt = sx_r;
      box_min_y_nxt = sy_r;
      box_max_y_nxt = sy_r;
    end else begin
      box_min_x_nxt = (sx_r < box_min_x_r) ? sx_r : box_min_x_r;
      box_max_x_nxt = (sx_r > box_max_x_r) ? sx_r : box_max_x_r;
      box_min_y_nxt = (sy_r < box_min_y_r) ? sy_r : box_min_y_r;
      box_max_y_nxt = (sy_r > box_max_y_r) ? sy_r : box_max_y_r;
    end
  end

  always_comb begin
    if (ctrl.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_if.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r   <= COS_RST;
      sin_r   <= '0;
      scale_r <= SCALE_RST;
      cx_r    <= '0;
      cy_r    <= '0;
      voff_r  <= '0;
      eye_r   <= EYE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COS_YAW:         cos_r   <= cfg_wdata;
        REG_SIN_YAW:         sin_r   <= cfg_wdata;
        REG_SCALE:           scale_r <= cfg_wdata;
        REG_CENTER_X:        cx_r    <= cfg_wdata;
        REG_CENTER_Y:        cy_r    <= cfg_wdata;
        REG_VERTICAL_OFFSET: voff_r  <= cfg_wdata;
        REG_EYE_DISTANCE:    eye_r   <= cfg_wdata;
        default:             ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      box_min_x_r <= BOX_HI;
      box_min_y_r <= BOX_HI;
      box_max_x_r <= BOX_LO;
      box_max_y_r <= BOX_LO;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (ctrl.finish) begin
        box_min_x_r <= box_min_x_nxt;
        box_min_y_r <= box_min_y_nxt;
        box_max_x_r <= box_max_x_nxt;
        box_max_y_r <= box_max_y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    if (in_fire) begin
      first_r <= in_if.first_vertex;
      x_r     <= in_if.pos_x;
      z_r     <= in_if.pos_z;
      yo_r    <= VW'(in_if.pos_y) + VW'(voff_r);
      u_r     <= in_if.tex_u;
      v_r     <= in_if.tex_v;
    end
    if (ctrl.cap_xr) xr_r <= acc_rnd1[FRAC_BITS +: VW];
    if (ctrl.cap_zr) zr_r <= acc_rnd1[FRAC_BITS +: VW];
    if (ctrl.cap_den) den_r <= den_nxt;
    if (ctrl.cap_k) k_r <= prod[K_W-1:0];
    if (ctrl.cap_px) px_r <= acc_rnd2[2*FRAC_BITS +: PJW];
    if (ctrl.cap_sx) sx_r <= sx_sat[SW-1:0];
    if (ctrl.cap_py) py_r <= acc_rnd2[2*FRAC_BITS +: PJW];
    if (ctrl.cap_sy) sy_r <= sy_sat[SW-1:0];
    if (ctrl.finish) begin
      o_sx_r    <= sx_r;
      o_sy_r    <= sy_r;
      o_depth_r <= depth_sat[CW-1:0];
      o_u_r     <= u_r;
      o_v_r     <= v_r;
    end
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.screen_x    = o_sx_r;
  assign out_if.screen_y    = o_sy_r;
  assign out_if.depth       = o_depth_r;
  assign out_if.out_u       = o_u_r;
  assign out_if.out_v       = o_v_r;
  assign out_if.bound_min_x = box_min_x_r;
  assign out_if.bound_min_y = box_min_y_r;
  assign out_if.bound_max_x = box_max_x_r;
  assign out_if.bound_max_y = box_max_y_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_if.ready)
    else $error("input taken again before the vertex finished");

  a_box_holds_x: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.bound_min_x <= out_if.screen_x) &&
                     (out_if.screen_x <= out_if.bound_max_x))
    else $error("bounding box misses screen_x");

  a_box_holds_y: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid |-> (out_if.bound_min_y <= out_if.screen_y) &&
                     (out_if.screen_y <= out_if.bound_max_y))
    else $error("bounding box misses screen_y");

endmodule

`default_nettype wire

// ===== rtl/vpp_mul.sv =====
`default_nettype none

module vpp_mul #(
  parameter int A_W = 21
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic signed [A_W-1:0]                    a_i,
  input  logic signed [vpp_pkg::MUL_B_W-1:0]       b_i,
  input  vpp_pkg::acc_op_t                         op_i,
  output logic signed [A_W+vpp_pkg::MUL_B_W-1:0]   prod_o,
  output vpp_pkg::acc_op_t                         op_o
);
  import vpp_pkg::*;

  logic signed [A_W+MUL_B_W-1:0] prod_r;
  logic signed [A_W+MUL_B_W-1:0] prod_nxt;
  acc_op_t                       op_r;

  assign prod_nxt = a_i * b_i;

  // product and its accumulate op travel together into the next cycle
  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r <= ACC_HOLD;
    end else begin
      op_r <= op_i;
    end
  end

  assign prod_o = prod_r;
  assign op_o   = op_r;

endmodule

`default_nettype wire

// ===== rtl/vpp_div.sv =====
`default_nettype none

module vpp_div #(
  parameter int DEN_W = 17
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start_i,
  input  logic [vpp_pkg::CFG_W-1:0]    eye_i,
  input  logic [DEN_W-1:0]             den_i,
  output logic                         busy_o,
  output logic [vpp_pkg::QUOT_W-1:0]   quot_o
);
  import vpp_pkg::*;

  localparam int NUM_W = CFG_W + FRAC_BITS;
  localparam int CMP_W = DEN_W + NUM_W;
  localparam int CNT_W = $clog2(QUOT_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUOT_W - 1);

  logic [NUM_W-1:0]  num;
  logic [DEN_W:0]    trial;
  logic              fits;
  logic [DEN_W-1:0]  rem_r, rem_nxt;
  logic [QUOT_W-1:0] sh_r, sh_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              sat_r, sat_nxt;

  assign num   = {eye_i, {FRAC_BITS{1'b0}}};
  assign trial = {rem_r, sh_r[QUOT_W-1]};
  assign fits  = trial >= {1'b0, den_i};

  // restoring division, one quotient bit per cycle; quotient shifts in
  // behind the numerator bits still to be consumed
  always_comb begin
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    sat_nxt  = sat_r;
    if (start_i) begin
      rem_nxt  = DEN_W'(num[NUM_W-1:QUOT_W]);
      sh_nxt   = num[QUOT_W-1:0];
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      // quotient would not fit in QUOT_W bits
      sat_nxt  = CMP_W'(num) >= CMP_W'({den_i, {QUOT_W{1'b0}}});
    end else if (busy_r) begin
      rem_nxt = fits ? DEN_W'(trial - {1'b0, den_i}) : trial[DEN_W-1:0];
      sh_nxt  = {sh_r[QUOT_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    sat_r <= sat_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign busy_o = busy_r;
  assign quot_o = sat_r ? {QUOT_W{1'b1}} : sh_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> !busy_r)
    else $error("divider restarted while busy");

  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> den_i != '0)
    else $error("divider started with zero divisor");

  a_last_step: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && cnt_r == CNT_LAST |=> !busy_r)
    else $error("divider ran past its last step");

endmodule

`default_nettype wire

// ===== rtl/vpp_seq.sv =====
`default_nettype none

module vpp_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_fire_i,
  input  logic               div_busy_i,
  input  logic               out_free_i,
  output vpp_pkg::vpp_ctrl_t ctrl_o
);
  import vpp_pkg::*;

  vpp_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_fire_i) state_nxt = ST_XC;
      ST_XC:     state_nxt = ST_ZS;
      ST_ZS:     state_nxt = ST_XS;
      ST_XS:     state_nxt = ST_ZC;
      ST_ZC:     state_nxt = ST_ZACC;
      ST_ZACC:   state_nxt = ST_ZR;
      ST_ZR:     state_nxt = ST_DEN;
      ST_DEN:    state_nxt = ST_DSTART;
      ST_DSTART: state_nxt = ST_DWAIT;
      ST_DWAIT:  if (!div_busy_i) state_nxt = ST_KMUL;
      ST_KMUL:   state_nxt = ST_KCAP;
      ST_KCAP:   state_nxt = ST_XLO;
      ST_XLO:    state_nxt = ST_XHI;
      ST_XHI:    state_nxt = ST_YLO;
      ST_YLO:    state_nxt = ST_YHI;
      ST_YHI:    state_nxt = ST_YACC;
      ST_YACC:   state_nxt = ST_PY;
      ST_PY:     state_nxt = ST_SY;
      ST_SY:     state_nxt = ST_DONE;
      ST_DONE:   if (out_free_i) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // the accumulate op is applied in the cycle after it is issued, with the registered product
  always_comb begin
    ctrl_o.a_sel     = A_X;
    ctrl_o.b_sel     = B_COS;
    ctrl_o.acc_op    = ACC_HOLD;
    ctrl_o.in_ready  = 1'b0;
    ctrl_o.cap_xr    = 1'b0;
    ctrl_o.cap_zr    = 1'b0;
    ctrl_o.cap_den   = 1'b0;
    ctrl_o.div_start = 1'b0;
    ctrl_o.cap_k     = 1'b0;
    ctrl_o.cap_px    = 1'b0;
    ctrl_o.cap_sx    = 1'b0;
    ctrl_o.cap_py    = 1'b0;
    ctrl_o.cap_sy    = 1'b0;
    ctrl_o.finish    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
      end
      ST_XC: begin
        ctrl_o.a_sel  = A_X;
        ctrl_o.b_sel  = B_COS;
        ctrl_o.acc_op = ACC_LOAD;
      end
      ST_ZS: begin
        ctrl_o.a_sel  = A_Z;
        ctrl_o.b_sel  = B_SIN;
        ctrl_o.acc_op = ACC_SUB;
      end
      ST_XS: begin
        ctrl_o.a_sel  = A_X;
        ctrl_o.b_sel  = B_SIN;
        ctrl_o.acc_op = ACC_LOAD;
      end
      ST_ZC: begin
        ctrl_o.a_sel  = A_Z;
        ctrl_o.b_sel  = B_COS;
        ctrl_o.acc_op = ACC_ADD;
        ctrl_o.cap_xr = 1'b1;
      end
      ST_ZR: begin
        ctrl_o.cap_zr = 1'b1;
      end
      ST_DEN: begin
        ctrl_o.cap_den = 1'b1;
      end
      ST_DSTART: begin
        ctrl_o.div_start = 1'b1;
      end
      ST_KMUL: begin
        ctrl_o.a_sel = A_P;
        ctrl_o.b_sel = B_SCALE;
      end
      ST_KCAP: begin
        ctrl_o.cap_k = 1'b1;
      end
      ST_XLO: begin
        ctrl_o.a_sel  = A_XR;
        ctrl_o.b_sel  = B_K_LO;
        ctrl_o.acc_op = ACC_LOAD;
      end
      ST_XHI: begin
        ctrl_o.a_sel  = A_XR;
        ctrl_o.b_sel  = B_K_HI;
        ctrl_o.acc_op = ACC_ADD_HI;
      end
      ST_YLO: begin
        ctrl_o.a_sel  = A_YO;
        ctrl_o.b_sel  = B_K_LO;
        ctrl_o.acc_op = ACC_LOAD;
      end
      ST_YHI: begin
        ctrl_o.a_sel  = A_YO;
        ctrl_o.b_sel  = B_K_HI;
        ctrl_o.acc_op = ACC_ADD_HI;
        ctrl_o.cap_px = 1'b1;
      end
      ST_YACC: begin
        ctrl_o.cap_sx = 1'b1;
      end
      ST_PY: begin
        ctrl_o.cap_py = 1'b1;
      end
      ST_SY: begin
        ctrl_o.cap_sy = 1'b1;
      end
      ST_DONE: begin
        ctrl_o.finish = out_free_i;
      end
      default: begin
        ctrl_o.in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== bench/vertex_perspective_project_unit_tb.sv =====
`default_nettype none

module vertex_perspective_project_unit_tb;
  import vpp_pkg::*;

  localparam int COORD_W     = 16;
  localparam int SCR_W       = 20;
  localparam int QUIET_LIMIT = 4000;
  localparam int SETTLE      = 50;
  localparam int PHASE_ITEMS = 55;

  localparam longint PERSP_MAX = (64'sd1 <<< 20) - 1;
  localparam longint SCR_MAX   = (64'sd1 <<< (SCR_W - 1)) - 1;
  localparam longint SCR_MIN   = -SCR_MAX - 1;
  localparam longint CRD_MAX   = (64'sd1 <<< (COORD_W - 1)) - 1;
  localparam longint CRD_MIN   = -CRD_MAX - 1;

  // index past the register list, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic                      first_vertex;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic [TEX_W-1:0]          tex_u;
    logic [TEX_W-1:0]          tex_v;
  } vertex_t;

  typedef struct packed {
    logic signed [SCR_W-1:0]   screen_x;
    logic signed [SCR_W-1:0]   screen_y;
    logic signed [COORD_W-1:0] depth;
    logic [TEX_W-1:0]          out_u;
    logic [TEX_W-1:0]          out_v;
    logic signed [SCR_W-1:0]   bound_min_x;
    logic signed [SCR_W-1:0]   bound_min_y;
    logic signed [SCR_W-1:0]   bound_max_x;
    logic signed [SCR_W-1:0]   bound_max_y;
  } proj_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  vpp_in_if  #(.COORD_WIDTH(COORD_W)) in_ch ();
  vpp_out_if #(.COORD_WIDTH(COORD_W), .SCREEN_WIDTH(SCR_W)) out_ch ();

  vertex_perspective_project_unit #(
    .COORD_WIDTH (COORD_W),
    .SCREEN_WIDTH(SCR_W)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_if    (in_ch),
    .out_if   (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vertex_t    vertex_q[$];
  proj_t      proj_q[$];
  logic [15:0] reg_file [0:6];
  longint     box_min_x, box_min_y, box_max_x, box_max_y;
  int         fail_count = 0;
  int         quiet_cycles = 0;

  function automatic longint round_shift(longint v, int sh);
    return (v + (64'sd1 <<< (sh - 1))) >>> sh;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // projection of one vertex; also advances the running bounding box
  function automatic proj_t project_vertex(vertex_t v);
    longint x, y, z, c, s, eye, sc, xr, zr, yo, den, p, sx, sy, dz;
    proj_t  r;
    x   = longint'(v.pos_x);
    y   = longint'(v.pos_y);
    z   = longint'(v.pos_z);
    c   = longint'($signed(reg_file[REG_COS_YAW]));
    s   = longint'($signed(reg_file[REG_SIN_YAW]));
    sc  = longint'(reg_file[REG_SCALE]);
    eye = longint'(reg_file[REG_EYE_DISTANCE]);
    xr  = round_shift(x * c - z * s, FRAC_BITS);
    zr  = round_shift(x * s + z * c, FRAC_BITS);
    yo  = y + longint'($signed(reg_file[REG_VERTICAL_OFFSET]));
    // at or behind the eye: divide by one; the factor then pins at max for eye of 64 or more
    den = eye + zr;
    if (den <= 0) den = 1;
    p = (eye <<< FRAC_BITS) / den;
    if (p > PERSP_MAX) p = PERSP_MAX;
    sx = longint'(reg_file[REG_CENTER_X]) + round_shift(xr * sc * p, 2 * FRAC_BITS);
    sy = longint'(reg_file[REG_CENTER_Y]) - round_shift(yo * sc * p, 2 * FRAC_BITS);
    sx = clamp(sx, SCR_MIN, SCR_MAX);
    sy = clamp(sy, SCR_MIN, SCR_MAX);
    dz = clamp(zr, CRD_MIN, CRD_MAX);
    if (v.first_vertex) begin
      box_min_x = sx;
      box_max_x = sx;
      box_min_y = sy;
      box_max_y = sy;
    end else begin
      if (sx < box_min_x) box_min_x = sx;
      if (sx > box_max_x) box_max_x = sx;
      if (sy < box_min_y) box_min_y = sy;
      if (sy > box_max_y) box_max_y = sy;
    end
    r.screen_x    = sx[SCR_W-1:0];
    r.screen_y    = sy[SCR_W-1:0];
    r.depth       = dz[COORD_W-1:0];
    r.out_u       = v.tex_u;
    r.out_v       = v.tex_v;
    r.bound_min_x = box_min_x[SCR_W-1:0];
    r.bound_min_y = box_min_y[SCR_W-1:0];
    r.bound_max_x = box_max_x[SCR_W-1:0];
    r.bound_max_y = box_max_y[SCR_W-1:0];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [SCR_W-1:0] want,
                             input logic [SCR_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // monitor: tracks config writes, predicts on each accepted request, checks results
  always @(posedge clk) begin : monitor
    vertex_t seen;
    proj_t   want;
    if (!rst_n) begin
      reg_file[REG_COS_YAW]         = 16'd16384;
      reg_file[REG_SIN_YAW]         = 16'd0;
      reg_file[REG_SCALE]           = 16'd4096;
      reg_file[REG_CENTER_X]        = 16'd0;
      reg_file[REG_CENTER_Y]        = 16'd0;
      reg_file[REG_VERTICAL_OFFSET] = 16'd0;
      reg_file[REG_EYE_DISTANCE]    = 16'd29491;
      box_min_x = SCR_MAX;
      box_min_y = SCR_MAX;
      box_max_x = SCR_MIN;
      box_max_y = SCR_MIN;
      proj_q.delete();
    end else begin
      if (cfg_we && cfg_index <= REG_EYE_DISTANCE) reg_file[cfg_index] = cfg_wdata;
      if (out_ch.valid && out_ch.ready) begin
        if (proj_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          fail_count++;
        end else begin
          want = proj_q.pop_front();
          check_field("screen_x", want.screen_x, out_ch.screen_x);
          check_field("screen_y", want.screen_y, out_ch.screen_y);
          check_field("depth", SCR_W'(want.depth), SCR_W'(out_ch.depth));
          check_field("out_u", SCR_W'(want.out_u), SCR_W'(out_ch.out_u));
          check_field("out_v", SCR_W'(want.out_v), SCR_W'(out_ch.out_v));
          check_field("bound_min_x", want.bound_min_x, out_ch.bound_min_x);
          check_field("bound_min_y", want.bound_min_y, out_ch.bound_min_y);
          check_field("bound_max_x", want.bound_max_x, out_ch.bound_max_x);
          check_field("bound_max_y", want.bound_max_y, out_ch.bound_max_y);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        seen.first_vertex = in_ch.first_vertex;
        seen.pos_x        = in_ch.pos_x;
        seen.pos_y        = in_ch.pos_y;
        seen.pos_z        = in_ch.pos_z;
        seen.tex_u        = in_ch.tex_u;
        seen.tex_v        = in_ch.tex_v;
        proj_q = {proj_q, project_vertex(seen)};
      end
    end
  end

  // request driver: bursts of random length separated by random gaps
  int      burst_left = 1;
  int      gap_left = 0;
  vertex_t next_vertex;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid        <= 1'b0;
      in_ch.first_vertex <= 1'b0;
      in_ch.pos_x        <= '0;
      in_ch.pos_y        <= '0;
      in_ch.pos_z        <= '0;
      in_ch.tex_u        <= '0;
      in_ch.tex_v        <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0 || vertex_q.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_ch.valid <= 1'b0;
      end else begin
        next_vertex = vertex_q.pop_front();
        in_ch.first_vertex <= next_vertex.first_vertex;
        in_ch.pos_x        <= next_vertex.pos_x;
        in_ch.pos_y        <= next_vertex.pos_y;
        in_ch.pos_z        <= next_vertex.pos_z;
        in_ch.tex_u        <= next_vertex.tex_u;
        in_ch.tex_v        <= next_vertex.tex_v;
        in_ch.valid        <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end
      end
    end
  end

  // result receiver: switches between always ready, coin flip and mostly stalled
  int stall_mode = 0;
  int mode_left = 0;

  always @(posedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(20, 300);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
      default: out_ch.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic add_vertex(input logic first, input int x, input int y, input int z,
                            input int u, input int v);
    vertex_t t;
    t.first_vertex = first;
    t.pos_x        = x[COORD_W-1:0];
    t.pos_y        = y[COORD_W-1:0];
    t.pos_z        = z[COORD_W-1:0];
    t.tex_u        = u[TEX_W-1:0];
    t.tex_v        = v[TEX_W-1:0];
    vertex_q = {vertex_q, t};
  endtask

  function automatic int coord_value();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 65535);
      1: begin
        case ($urandom_range(0, 3))
          0:       return 32767;
          1:       return -32768;
          2:       return 0;
          default: return -1;
        endcase
      end
      default: return int'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  task automatic add_extremes();
    add_vertex(1'b1, 0, 0, 0, 0, 0);
    add_vertex(1'b0, 32767, -32768, -32768, 65535, 0);
    add_vertex(1'b0, -32768, 32767, 32767, 0, 65535);
    add_vertex(1'b0, 16384, -16384, -29491, 65535, 65535);
    add_vertex(1'b0, -16384, 16384, 16384, 21845, 43690);
    add_vertex(1'b0, 1, -1, -1, 1, 32768);
  endtask

  // meshes: a first vertex then a run of followers, with some stray flags mixed in
  task automatic add_meshes(input int count);
    int left;
    int added;
    added = 0;
    while (added < count) begin
      add_vertex(1'b1, coord_value(), coord_value(), coord_value(),
                 $urandom_range(0, 65535), $urandom_range(0, 65535));
      added++;
      left = $urandom_range(1, 10);
      repeat (left) begin
        add_vertex(($urandom_range(0, 9) == 0), coord_value(), coord_value(),
                   coord_value(), $urandom_range(0, 65535), $urandom_range(0, 65535));
        added++;
      end
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_config(input int c, input int s, input int sc, input int cx,
                            input int cy, input int off, input int eye);
    write_reg(REG_COS_YAW, c);
    write_reg(REG_SIN_YAW, s);
    write_reg(REG_SCALE, sc);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_VERTICAL_OFFSET, off);
    write_reg(REG_EYE_DISTANCE, eye);
  endtask

  // hold new requests until every result is back and the block has gone quiet
  task automatic drain_requests();
    @(negedge clk);
    while (vertex_q.size() != 0 || in_ch.valid || proj_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings; box untouched by any first vertex at the start
    add_vertex(1'b0, 0, 0, 0, 0, 0);
    add_vertex(1'b0, 32767, -32768, 0, 65535, 65535);
    add_vertex(1'b0, -32768, 32767, 32767, 0, 0);
    add_vertex(1'b0, 16384, 16384, -29491, 4660, 43981);   // divisor exactly zero
    add_vertex(1'b0, -16384, -16384, -29490, 1, 2);        // divisor one
    add_vertex(1'b0, 100, 100, -32768, 3, 4);              // behind the eye
    add_vertex(1'b1, 8192, -8192, 8192, 4660, 43981);
    add_vertex(1'b0, -8192, 8192, -8192, 65535, 0);
    drain_requests();

    // out-of-range cosine, largest scale, centre and eye
    set_config(-32768, 32767, 65535, 65535, 65535, -32768, 65535);
    write_reg(REG_UNUSED, $urandom_range(0, 65535));
    @(negedge clk);
    add_extremes();
    add_meshes(PHASE_ITEMS);
    drain_requests();

    set_config(16384, -16384, 0, 0, 0, 32767, 16384);
    @(negedge clk);
    add_extremes();
    add_meshes(PHASE_ITEMS);
    drain_requests();

    // zero eye distance collapses everything onto the centre
    set_config(int'($urandom_range(0, 32768)) - 16384, int'($urandom_range(0, 32768)) - 16384,
               4096, 2560, 1920, 0, 0);
    @(negedge clk);
    add_extremes();
    add_meshes(PHASE_ITEMS);
    drain_requests();

    repeat (6) begin
      set_config(int'($urandom_range(0, 32768)) - 16384,
                 int'($urandom_range(0, 32768)) - 16384,
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                             : $urandom_range(256, 8192),
                 $urandom_range(0, 65535), $urandom_range(0, 65535),
                 int'($urandom_range(0, 32768)) - 16384,
                 $urandom_range(16384, 65535));
      write_reg(REG_UNUSED, $urandom_range(0, 65535));
      @(negedge clk);
      add_meshes(PHASE_ITEMS);
      drain_requests();
    end

    if (fail_count == 0 && proj_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/vpp_pkg.sv
rtl/vpp_if.sv
rtl/vpp_mul.sv
rtl/vpp_div.sv
rtl/vpp_seq.sv
rtl/vertex_perspective_project_unit.sv
bench/vertex_perspective_project_unit_tb.sv
